// ===== hw/rtl/box_overlap_metric_top_defines.svh =====
// ---------------------------------------------------------------------------
// Box overlap metric: assertion macros
// Shared assertion forms for the box overlap metric block.
// ---------------------------------------------------------------------------
`ifndef BOX_OVERLAP_METRIC_TOP_DEFINES_SVH
`define BOX_OVERLAP_METRIC_TOP_DEFINES_SVH

// same-cycle implication
`define BOM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("box_overlap_metric: check failed");

// next-cycle implication
`define BOM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("box_overlap_metric: check failed");

`endif

// ===== hw/rtl/bom_pkg.sv =====
// ---------------------------------------------------------------------------
// Box overlap metric package
// Widths, latencies, types and constant tables shared by the pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package bom_pkg;

  localparam int COORD_W    = 16;
  localparam int FB         = 24;
  localparam int ATAN_STEPS = 16;
  localparam int DIV_W      = 38;
  localparam int DIV_Q      = FB + 1;
  localparam int Z_W        = 28;
  localparam int OUT_W      = 16;

  localparam int GEO_LAT    = 3;
  localparam int DIV_LAT    = DIV_Q;
  localparam int ASP_LAT    = ATAN_STEPS + 3;
  localparam int POW_LAT    = 2 * FB + 5;
  localparam int VLD_N      = GEO_LAT + DIV_LAT + POW_LAT;

  localparam logic [FB:0]   ONE_Q        = 25'(1) << FB;
  localparam logic [FB:0]   HALF_PI_Q    = 25'd26353589;
  localparam logic [22:0]   FOUR_PI2_Q   = 23'd6799550;
  localparam logic [FB:0]   EPS_Q        = 25'd17;
  localparam logic [31:0]   RECIP_FIVE   = 32'hCCCC_CCCD;

  typedef enum logic [1:0] {
    KIND_IOU  = 2'd0,
    KIND_GIOU = 2'd1,
    KIND_DIOU = 2'd2,
    KIND_CIOU = 2'd3
  } kind_t;

  typedef struct packed {
    logic iou_ok;
    logic area_ok;
    logic diag_ok;
  } flags_t;

  typedef struct packed {
    logic [DIV_W-1:0] inter;
    logic [DIV_W-1:0] uni;
    logic [DIV_W-1:0] empty;
    logic [DIV_W-1:0] area;
    logic [DIV_W-1:0] dist_sq;
    logic [DIV_W-1:0] diag;
    flags_t           flags;
  } geo_t;

  typedef struct packed {
    flags_t      flags;
    logic [FB:0] iou;
    logic [FB:0] gfrac;
    logic [FB:0] ratio;
  } side_t;

  function automatic logic [FB:0] atan_const(input int idx);
    logic [FB:0] val;
    case (idx)
      0:       val = 25'd13176795;
      1:       val = 25'd7778716;
      2:       val = 25'd4110060;
      3:       val = 25'd2086331;
      4:       val = 25'd1047214;
      5:       val = 25'd524117;
      6:       val = 25'd262123;
      7:       val = 25'd131069;
      8:       val = 25'd65536;
      9:       val = 25'd32768;
      10:      val = 25'd16384;
      11:      val = 25'd8192;
      12:      val = 25'd4096;
      13:      val = 25'd2048;
      14:      val = 25'd1024;
      15:      val = 25'd512;
      16:      val = 25'd256;
      17:      val = 25'd128;
      18:      val = 25'd64;
      19:      val = 25'd32;
      20:      val = 25'd16;
      21:      val = 25'd8;
      22:      val = 25'd4;
      23:      val = 25'd2;
      default: val = '0;
    endcase
    return val;
  endfunction

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // factor 2^(-2^-(j+1)) in Q.24, chained square roots from one half
  function automatic logic [63:0] exp_factor(input int j);
    logic [63:0] c;
    c = 64'd1 << (FB - 1);
    for (int k = 0; k <= j; k++) begin
      c = isqrt64(c << FB);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bom_geom.sv =====
// ---------------------------------------------------------------------------
// Box overlap metric: geometry front end
// Three stages: edges and spans, products, union / enclosing / distance.
// ---------------------------------------------------------------------------
`default_nettype none

module bom_geom import bom_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [COORD_W-1:0] a_x,
  input  wire logic [COORD_W-1:0] a_y,
  input  wire logic [COORD_W-1:0] a_w,
  input  wire logic [COORD_W-1:0] a_h,
  input  wire logic [COORD_W-1:0] b_x,
  input  wire logic [COORD_W-1:0] b_y,
  input  wire logic [COORD_W-1:0] b_w,
  input  wire logic [COORD_W-1:0] b_h,
  output geo_t                    geo
);

  localparam int EDGE_W = COORD_W + 3;
  localparam int DIFF_W = COORD_W + 4;
  localparam int SPAN_W = COORD_W + 2;
  localparam int DD_W   = COORD_W + 1;
  localparam int PA_W   = 2 * COORD_W;
  localparam int PS_W   = 2 * SPAN_W;
  localparam int PD_W   = 2 * DD_W;

  logic signed [EDGE_W-1:0] la, ra, ta, ba, lb, rb, tb, bb;
  logic signed [EDGE_W-1:0] rmin, rmax, lmin, lmax, bmin, bmax, tmin, tmax;
  logic signed [EDGE_W-1:0] cw_n, ch_n;
  logic signed [DIFF_W-1:0] iw_n, ih_n;
  logic [COORD_W-1:0]       dx_n, dy_n;

  // stage 1
  logic signed [DIFF_W-1:0] iw, ih;
  logic [SPAN_W-1:0]        cw, ch;
  logic [DD_W-1:0]          adx, ady;
  logic [COORD_W-1:0]       aw1, ah1, bw1, bh1;

  // stage 2
  logic [PS_W-1:0]          inter, area, cw2, ch2;
  logic [PA_W-1:0]          area_a, area_b;
  logic [PD_W-1:0]          dx2, dy2;

  logic [PS_W-1:0]          uni_n, empty_n;
  logic [PS_W:0]            diag_n;
  logic [PD_W:0]            dist_n;

  always_comb begin
    la = $signed({2'b00, a_x, 1'b0}) - $signed({3'b000, a_w});
    ra = $signed({2'b00, a_x, 1'b0}) + $signed({3'b000, a_w});
    ta = $signed({2'b00, a_y, 1'b0}) - $signed({3'b000, a_h});
    ba = $signed({2'b00, a_y, 1'b0}) + $signed({3'b000, a_h});
    lb = $signed({2'b00, b_x, 1'b0}) - $signed({3'b000, b_w});
    rb = $signed({2'b00, b_x, 1'b0}) + $signed({3'b000, b_w});
    tb = $signed({2'b00, b_y, 1'b0}) - $signed({3'b000, b_h});
    bb = $signed({2'b00, b_y, 1'b0}) + $signed({3'b000, b_h});
    rmin = (ra < rb) ? ra : rb;
    rmax = (ra > rb) ? ra : rb;
    lmin = (la < lb) ? la : lb;
    lmax = (la > lb) ? la : lb;
    bmin = (ba < bb) ? ba : bb;
    bmax = (ba > bb) ? ba : bb;
    tmin = (ta < tb) ? ta : tb;
    tmax = (ta > tb) ? ta : tb;
    iw_n = DIFF_W'(rmin) - DIFF_W'(lmax);
    ih_n = DIFF_W'(bmin) - DIFF_W'(tmax);
    cw_n = rmax - lmin;
    ch_n = bmax - tmin;
    dx_n = (a_x >= b_x) ? a_x - b_x : b_x - a_x;
    dy_n = (a_y >= b_y) ? a_y - b_y : b_y - a_y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      iw  <= iw_n;
      ih  <= ih_n;
      cw  <= cw_n[SPAN_W-1:0];
      ch  <= ch_n[SPAN_W-1:0];
      adx <= {dx_n, 1'b0};
      ady <= {dy_n, 1'b0};
      aw1 <= a_w;
      ah1 <= a_h;
      bw1 <= b_w;
      bh1 <= b_h;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (iw > 0 && ih > 0) begin
        inter <= PS_W'(iw[SPAN_W-1:0]) * PS_W'(ih[SPAN_W-1:0]);
      end else begin
        inter <= '0;
      end
      area_a <= PA_W'(aw1) * PA_W'(ah1);
      area_b <= PA_W'(bw1) * PA_W'(bh1);
      area   <= PS_W'(cw) * PS_W'(ch);
      cw2    <= PS_W'(cw) * PS_W'(cw);
      ch2    <= PS_W'(ch) * PS_W'(ch);
      dx2    <= PD_W'(adx) * PD_W'(adx);
      dy2    <= PD_W'(ady) * PD_W'(ady);
    end
  end

  always_comb begin
    uni_n   = {area_a, 2'b00} + {area_b, 2'b00} - inter;
    diag_n  = {1'b0, cw2} + {1'b0, ch2};
    dist_n  = {1'b0, dx2} + {1'b0, dy2};
    empty_n = (area > uni_n) ? area - uni_n : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      geo.inter         <= DIV_W'(inter);
      geo.uni           <= DIV_W'(uni_n);
      geo.empty         <= DIV_W'(empty_n);
      geo.area          <= DIV_W'(area);
      geo.dist_sq       <= DIV_W'(dist_n);
      geo.diag          <= DIV_W'(diag_n);
      geo.flags.iou_ok  <= (inter != '0) && (uni_n != '0);
      geo.flags.area_ok <= (area != '0);
      geo.flags.diag_ok <= (diag_n != '0);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bom_div.sv =====
// ---------------------------------------------------------------------------
// Box overlap metric: pipelined divider
// Restoring division of num * 2^24 by den, one quotient bit per stage.
// Quotient must fit in 25 bits.
// ---------------------------------------------------------------------------
`default_nettype none

module bom_div import bom_pkg::*; (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [DIV_W-1:0] num,
  input  wire logic [DIV_W-1:0] den,
  output logic      [DIV_Q-1:0] quo
);

  localparam int REM_W = DIV_W + FB;

  logic [REM_W-1:0] rem_r [DIV_Q];
  logic [DIV_W-1:0] den_r [DIV_Q];
  logic [DIV_Q-1:0] quo_r [DIV_Q];

  for (genvar s = 0; s < DIV_Q; s++) begin : g_stage
    logic [REM_W-1:0] rem_in;
    logic [REM_W-1:0] dsh;
    logic [DIV_W-1:0] den_in;
    logic [DIV_Q-1:0] quo_in;
    logic             ge;

    if (s == 0) begin : g_first
      assign rem_in = {num, {FB{1'b0}}};
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    assign dsh = {den_in, {FB{1'b0}}} >> s;
    assign ge  = (rem_in >= dsh);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? rem_in - dsh : rem_in;
        den_r[s] <= den_in;
        quo_r[s] <= {quo_in[DIV_Q-2:0], ge};
      end
    end
  end

  assign quo = quo_r[DIV_Q-1];

endmodule

`default_nettype wire

// ===== hw/rtl/bom_aspect.sv =====
// ---------------------------------------------------------------------------
// Box overlap metric: aspect term
// Two CORDIC lanes for atan(w/h), then v = (4/pi^2) * (atan_b - atan_a)^2.
// ---------------------------------------------------------------------------
`default_nettype none

module bom_aspect import bom_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic [COORD_W-1:0] a_w,
  input  wire logic [COORD_W-1:0] a_h,
  input  wire logic [COORD_W-1:0] b_w,
  input  wire logic [COORD_W-1:0] b_h,
  output logic      [FB:0]        v
);

  localparam int X_W = COORD_W + 20;
  localparam int SQ_W = FB + 2;

  logic [COORD_W-1:0]      w_in  [2];
  logic [COORD_W-1:0]      h_in  [2];
  logic signed [Z_W-1:0]   z_fin [2];

  logic signed [Z_W-1:0]   df;
  logic signed [2*Z_W-1:0] df_sq;
  logic [SQ_W-1:0]         sq;
  logic [SQ_W+22:0]        v_prod;

  assign w_in[0] = a_w;
  assign h_in[0] = a_h;
  assign w_in[1] = b_w;
  assign h_in[1] = b_h;

  for (genvar ln = 0; ln < 2; ln++) begin : g_lane
    logic signed [X_W-1:0] x_r  [ATAN_STEPS];
    logic signed [X_W-1:0] y_r  [ATAN_STEPS];
    logic signed [Z_W-1:0] z_r  [ATAN_STEPS];
    logic                  hz_r [ATAN_STEPS];

    for (genvar i = 0; i < ATAN_STEPS; i++) begin : g_step
      logic signed [X_W-1:0] xi, yi, xs, ys;
      logic signed [Z_W-1:0] zi, ti;
      logic                  hzi;

      if (i == 0) begin : g_init
        assign xi  = $signed({4'b0000, h_in[ln], 16'h0000});
        assign yi  = $signed({4'b0000, w_in[ln], 16'h0000});
        assign zi  = '0;
        assign hzi = (h_in[ln] == '0);
      end else begin : g_chain
        assign xi  = x_r[i-1];
        assign yi  = y_r[i-1];
        assign zi  = z_r[i-1];
        assign hzi = hz_r[i-1];
      end

      assign xs = xi >>> i;
      assign ys = yi >>> i;
      assign ti = $signed(Z_W'(atan_const(i)));

      always_ff @(posedge clk) begin
        if (en) begin
          if (!yi[X_W-1]) begin
            x_r[i] <= xi + ys;
            y_r[i] <= yi - xs;
            z_r[i] <= zi + ti;
          end else begin
            x_r[i] <= xi - ys;
            y_r[i] <= yi + xs;
            z_r[i] <= zi - ti;
          end
          hz_r[i] <= hzi;
        end
      end
    end

    assign z_fin[ln] = hz_r[ATAN_STEPS-1] ? $signed(Z_W'(HALF_PI_Q)) : z_r[ATAN_STEPS-1];
  end

  assign df_sq  = df * df;
  assign v_prod = (SQ_W+23)'(sq) * (SQ_W+23)'(FOUR_PI2_Q);

  always_ff @(posedge clk) begin
    if (en) begin
      df <= z_fin[1] - z_fin[0];
      sq <= df_sq[FB+SQ_W-1:FB];
      v  <= v_prod[2*FB:FB];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bom_pow.sv =====
// ---------------------------------------------------------------------------
// Box overlap metric: power 0.6
// Normalize, 24 squaring steps of log2, scale by 3/5, 24 steps of exp2.
// ---------------------------------------------------------------------------
`default_nettype none

module bom_pow import bom_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [FB:0] r,
  output logic      [FB:0] pw
);

  localparam int P_W   = 5;
  localparam int MAG_W = FB + P_W;
  localparam int M3_W  = MAG_W + 2;

  // normalize
  logic [P_W-1:0]   p_n;
  logic [FB:0]      r1;
  logic [P_W-1:0]   p1;
  logic             rz1;
  logic [2*FB:0]    m_sh;
  logic [FB:0]      m2;
  logic [P_W-1:0]   p2;
  logic             rz2;

  // log2
  logic [FB:0]      m_s  [FB];
  logic [FB-1:0]    fr_s [FB];
  logic [P_W-1:0]   p_s  [FB];
  logic             rz_s [FB];

  // scale
  logic [MAG_W-1:0] mag_n;
  logic [M3_W-1:0]  mag3;
  logic             rz3;
  logic [M3_W+31:0] tm_prod;
  logic [P_W-1:0]   ip4;
  logic [FB-1:0]    fp4;
  logic             rz4;

  // exp2
  logic [FB:0]      y_e  [FB];
  logic [FB-1:0]    fp_e [FB];
  logic [P_W-1:0]   ip_e [FB];
  logic             rz_e [FB];

  always_comb begin
    p_n = '0;
    for (int i = 0; i <= FB; i++) begin
      if (r[i]) begin
        p_n = P_W'(i);
      end
    end
  end

  assign m_sh = {{FB{1'b0}}, r1} << (P_W'(FB) - p1);

  always_ff @(posedge clk) begin
    if (en) begin
      r1  <= r;
      p1  <= p_n;
      rz1 <= (r == '0);
      m2  <= m_sh[FB:0];
      p2  <= p1;
      rz2 <= rz1;
    end
  end

  for (genvar j = 0; j < FB; j++) begin : g_log
    logic [FB:0]       mi;
    logic [FB-1:0]     fi;
    logic [P_W-1:0]    pi_s;
    logic              zi;
    logic [2*FB+1:0]   sqp;
    logic [FB+1:0]     t;

    if (j == 0) begin : g_first
      assign mi   = m2;
      assign fi   = '0;
      assign pi_s = p2;
      assign zi   = rz2;
    end else begin : g_chain
      assign mi   = m_s[j-1];
      assign fi   = fr_s[j-1];
      assign pi_s = p_s[j-1];
      assign zi   = rz_s[j-1];
    end

    assign sqp = (2*FB+2)'(mi) * (2*FB+2)'(mi);
    assign t   = sqp[2*FB+1:FB];

    always_ff @(posedge clk) begin
      if (en) begin
        if (t[FB+1]) begin
          m_s[j]  <= t[FB+1:1];
          fr_s[j] <= fi | (FB'(1) << (FB - 1 - j));
        end else begin
          m_s[j]  <= t[FB:0];
          fr_s[j] <= fi;
        end
        p_s[j]  <= pi_s;
        rz_s[j] <= zi;
      end
    end
  end

  assign mag_n   = {P_W'(FB) - p_s[FB-1], {FB{1'b0}}} - MAG_W'(fr_s[FB-1]);
  assign tm_prod = (M3_W+32)'(mag3) * (M3_W+32)'(RECIP_FIVE);

  always_ff @(posedge clk) begin
    if (en) begin
      mag3 <= M3_W'(mag_n) + (M3_W'(mag_n) << 1);
      rz3  <= rz_s[FB-1];
      ip4  <= tm_prod[34+FB+P_W-1:34+FB];
      fp4  <= tm_prod[34+FB-1:34];
      rz4  <= rz3;
    end
  end

  for (genvar j = 0; j < FB; j++) begin : g_exp
    localparam logic [63:0] CF = exp_factor(j);
    logic [FB:0]       yi;
    logic [FB-1:0]     fpi;
    logic [P_W-1:0]    ipi;
    logic              zi;
    logic [2*FB:0]     yp;

    if (j == 0) begin : g_first
      assign yi  = ONE_Q;
      assign fpi = fp4;
      assign ipi = ip4;
      assign zi  = rz4;
    end else begin : g_chain
      assign yi  = y_e[j-1];
      assign fpi = fp_e[j-1];
      assign ipi = ip_e[j-1];
      assign zi  = rz_e[j-1];
    end

    assign yp = (2*FB+1)'(yi) * (2*FB+1)'(CF[FB-1:0]);

    always_ff @(posedge clk) begin
      if (en) begin
        y_e[j]  <= fpi[FB-1-j] ? yp[2*FB:FB] : yi;
        fp_e[j] <= fpi;
        ip_e[j] <= ipi;
        rz_e[j] <= zi;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pw <= rz_e[FB-1] ? '0 : (y_e[FB-1] >> ip_e[FB-1]);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/box_overlap_metric_top.sv =====
// Path from input accept to result valid: geometry, divide and power sections,
//   then 1 output register.
// Throughput: one item per cycle; the whole pipeline stalls only while a result
//   waits on out_ready.
// Reset: rst synchronous active high; clears all valid bits and sets metric_kind
//   to plain IoU.
// ---------------------------------------------------------------------------
// Box overlap metric top level
// IoU / GIoU / DIoU / CIoU of two center-size boxes, signed Q2.14 output.
// ---------------------------------------------------------------------------
`default_nettype none

`include "box_overlap_metric_top_defines.svh"

module box_overlap_metric_top import bom_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [COORD_W-1:0] a_x,
  input  wire logic [COORD_W-1:0] a_y,
  input  wire logic [COORD_W-1:0] a_w,
  input  wire logic [COORD_W-1:0] a_h,
  input  wire logic [COORD_W-1:0] b_x,
  input  wire logic [COORD_W-1:0] b_y,
  input  wire logic [COORD_W-1:0] b_w,
  input  wire logic [COORD_W-1:0] b_h,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [OUT_W-1:0] metric
);

  localparam int V_DLY    = GEO_LAT + DIV_LAT - ASP_LAT;
  localparam int TERM_DLY = POW_LAT - DIV_LAT - 2;
  localparam int DEN_W    = FB + 2;
  localparam int RES_W    = FB + 5;
  localparam int Q_W      = RES_W - 10;

  kind_t              metric_kind;
  logic               en;
  logic [VLD_N-1:0]   vld;

  geo_t               geo;
  logic [DIV_Q-1:0]   q_iou, q_giou, q_ratio, q_alpha;
  logic [FB:0]        v_asp;
  logic [FB:0]        pw;

  flags_t             flg_d  [DIV_LAT];
  logic [FB:0]        v_d    [V_DLY];
  logic [FB:0]        av_d   [DIV_LAT];
  logic [FB+1:0]      term_d [TERM_DLY];
  side_t              side_d [POW_LAT];

  side_t              side_n;
  logic [FB:0]        av;
  logic [DEN_W-1:0]   aden;
  logic [2*FB+1:0]    term_prod;
  logic [FB+1:0]      term;

  side_t                    s3;
  logic signed [RES_W-1:0]  res;
  logic signed [RES_W-1:0]  rnd;
  logic signed [Q_W-1:0]    q_full;
  logic signed [OUT_W-1:0]  q_sat;

  assign cfg_ready = 1'b1;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      metric_kind <= KIND_IOU;
    end else if (cfg_valid) begin
      metric_kind <= kind_t'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[VLD_N-2:0], in_valid};
      out_valid <= vld[VLD_N-1];
    end
  end

  bom_geom u_geom (
    .clk (clk), .en (en),
    .a_x (a_x), .a_y (a_y), .a_w (a_w), .a_h (a_h),
    .b_x (b_x), .b_y (b_y), .b_w (b_w), .b_h (b_h),
    .geo (geo)
  );

  bom_aspect u_aspect (
    .clk (clk), .en (en),
    .a_w (a_w), .a_h (a_h), .b_w (b_w), .b_h (b_h),
    .v   (v_asp)
  );

  bom_div u_div_iou (
    .clk (clk), .en (en), .num (geo.inter), .den (geo.uni), .quo (q_iou)
  );

  bom_div u_div_giou (
    .clk (clk), .en (en), .num (geo.empty), .den (geo.area), .quo (q_giou)
  );

  bom_div u_div_ratio (
    .clk (clk), .en (en), .num (geo.dist_sq), .den (geo.diag), .quo (q_ratio)
  );

  // sideband delay lines
  always_ff @(posedge clk) begin
    if (en) begin
      flg_d[0] <= geo.flags;
      for (int i = 1; i < DIV_LAT; i++) flg_d[i] <= flg_d[i-1];
      v_d[0] <= v_asp;
      for (int i = 1; i < V_DLY; i++) v_d[i] <= v_d[i-1];
    end
  end

  always_comb begin
    side_n.flags = flg_d[DIV_LAT-1];
    side_n.iou   = side_n.flags.iou_ok ? q_iou : '0;
    side_n.gfrac = q_giou;
    side_n.ratio = q_ratio;
  end

  bom_pow u_pow (
    .clk (clk), .en (en), .r (q_ratio), .pw (pw)
  );

  // CIoU trade-off weight alpha = v / (1 - iou + v + eps)
  always_ff @(posedge clk) begin
    if (en) begin
      av   <= v_d[V_DLY-1];
      aden <= DEN_W'(ONE_Q) - DEN_W'(side_n.iou) + DEN_W'(v_d[V_DLY-1]) + DEN_W'(EPS_Q);
    end
  end

  bom_div u_div_alpha (
    .clk (clk), .en (en), .num (DIV_W'(av)), .den (DIV_W'(aden)), .quo (q_alpha)
  );

  assign term_prod = (2*FB+2)'(q_alpha) * (2*FB+2)'(av_d[DIV_LAT-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      av_d[0] <= av;
      for (int i = 1; i < DIV_LAT; i++) av_d[i] <= av_d[i-1];
      term <= term_prod[2*FB+1:FB];
      term_d[0] <= term;
      for (int i = 1; i < TERM_DLY; i++) term_d[i] <= term_d[i-1];
      side_d[0] <= side_n;
      for (int i = 1; i < POW_LAT; i++) side_d[i] <= side_d[i-1];
    end
  end

  assign s3 = side_d[POW_LAT-1];

  always_comb begin
    res = $signed(RES_W'(s3.iou));
    case (metric_kind)
      KIND_GIOU: begin
        if (s3.flags.area_ok) begin
          res = $signed(RES_W'(s3.iou)) - $signed(RES_W'(s3.gfrac));
        end
      end
      KIND_DIOU: begin
        if (s3.flags.diag_ok) begin
          res = $signed(RES_W'(s3.iou)) - $signed(RES_W'(pw));
        end
      end
      KIND_CIOU: begin
        if (s3.flags.diag_ok) begin
          res = $signed(RES_W'(s3.iou)) - $signed(RES_W'(s3.ratio))
              - $signed(RES_W'(term_d[TERM_DLY-1]));
        end
      end
      default: begin
        res = $signed(RES_W'(s3.iou));
      end
    endcase
    rnd    = res + $signed(RES_W'(512));
    q_full = Q_W'(rnd >>> 10);
    if (q_full > $signed(Q_W'(32767))) begin
      q_sat = 16'sh7FFF;
    end else if (q_full < -$signed(Q_W'(32768))) begin
      q_sat = 16'sh8000;
    end else begin
      q_sat = q_full[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      metric <= q_sat;
    end
  end

  `BOM_ASSERT_NOW(a_iou_nonneg, out_valid && metric_kind == KIND_IOU, !metric[OUT_W-1])
  `BOM_ASSERT_NOW(a_metric_max, out_valid, metric <= 16'sd16384)
  `BOM_ASSERT_NEXT(a_no_phantom, vld == '0 && !out_valid, !out_valid)

endmodule

`default_nettype wire
